/* rtl/multiturn_encoder_angle_velocity_core_defines.svh */
// shared assertion macros for the encoder tracking block
`ifndef MULTITURN_ENCODER_ANGLE_VELOCITY_CORE_DEFINES_SVH
`define MULTITURN_ENCODER_ANGLE_VELOCITY_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst is high
`define MTENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off while rst is high
`define MTENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mtenc_pkg.sv */
package mtenc_pkg;

  // field widths
  localparam int RAW_W      = 12;
  localparam int TIME_W     = 32;
  localparam int FA_W       = 24;
  localparam int VEL_W      = 32;
  localparam int EA_W       = 12;
  localparam int PP_W       = 7;
  localparam int ZERO_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO = 2'd2;

  localparam logic [PP_W-1:0] PP_RESET = 7'd7;

  // velocity scaling: counts per microsecond to counts per second
  localparam int VEL_SCALE   = 1000000;
  localparam int VEL_SCALE_W = 20;

  // elapsed-time window in microseconds
  localparam int DT_W       = 19;
  localparam int DT_LIMIT   = 500000;
  localparam int DT_DEFAULT = 1000;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_count;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [FA_W-1:0]  full_angle;
    logic signed [VEL_W-1:0] velocity;
    logic [EA_W-1:0]         elec_angle;
    logic                    primed;
  } out_item_t;

endpackage

/* rtl/mtenc_in_if.sv */
interface mtenc_in_if;
  logic                valid;
  logic                ready;
  mtenc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/mtenc_out_if.sv */
interface mtenc_out_if;
  logic                 valid;
  logic                 ready;
  mtenc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/mtenc_cfg_if.sv */
interface mtenc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mtenc_pkg::CFG_IDX_W-1:0]     index;
  logic [mtenc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/mtenc_div.sv */
module mtenc_div #(
  parameter int NW = 32,
  parameter int DW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [NW-1:0] qr;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_next;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem, qr[NW-1]};
    ge       = rem_sh >= {1'b0, den_q};
    rem_next = ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NW);
        rem   <= '0;
        qr    <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= rem_next;
        qr  <= {qr[NW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = qr;

endmodule

/* rtl/multiturn_encoder_angle_velocity_core.sv */
// one item in flight: a new sample is taken only after the last result is loaded for output;
//   the serial divider takes one quotient bit per cycle over COUNT_BITS + 20 bits
// a finished result waits in the output register while the next item is taken
// reset (synchronous, rst high): configuration registers to their defaults, tracking unprimed,
//   no result pending
module multiturn_encoder_angle_velocity_core #(
  parameter int COUNT_BITS   = 12,
  parameter int REBASE_TURNS = 2000
) (
  input logic         clk,
  input logic         rst,
  mtenc_in_if.sink    sample,
  mtenc_out_if.source result,
  mtenc_cfg_if.sink   cfg
);

  localparam int CB  = COUNT_BITS;
  localparam int TW  = $clog2(REBASE_TURNS) + 2;  // turn offset, holds +/-REBASE_TURNS
  localparam int AW  = TW + CB;                    // undirected angle
  localparam int PW  = AW + 1;                     // previous angle, may be shifted by a rebase
  localparam int DFW = CB + 1;                     // angle step, always below one turn
  localparam int NW  = CB + mtenc_pkg::VEL_SCALE_W;
  localparam int DTW = mtenc_pkg::DT_W;
  localparam int RW  = mtenc_pkg::RAW_W;

  localparam logic [RW-1:0] RAW_MASK =
    (COUNT_BITS >= RW) ? {RW{1'b1}} : RW'((1 << COUNT_BITS) - 1);
  localparam logic signed [TW-1:0] REB_T    = TW'(REBASE_TURNS);
  localparam logic signed [PW-1:0] REB_SPAN = PW'(REBASE_TURNS) << COUNT_BITS;

  // sequencer
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ANGLE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic                            reg_dir;
  logic [mtenc_pkg::PP_W-1:0]      reg_pp;
  logic [mtenc_pkg::ZERO_W-1:0]    reg_zero;

  // tracking state
  logic [CB-1:0]        prev_raw;
  logic signed [TW-1:0] turn_offset;
  logic signed [PW-1:0] prev_angle;
  logic [31:0]          prev_time;
  logic                 started;

  // per-item working registers
  logic [CB-1:0]                    raw_q;
  logic [31:0]                      now_q;
  logic signed [AW-1:0]             angle_q;
  logic signed [DFW-1:0]            diff_q;
  logic [DTW-1:0]                   dt_q;
  logic                             primed_q;
  logic [NW-1:0]                    num_q;
  logic                             neg_q;
  logic [mtenc_pkg::EA_W-1:0]       elec_q;
  logic signed [mtenc_pkg::FA_W-1:0] full_q;

  // output register
  logic                 res_valid;
  logic                 res_load;
  mtenc_pkg::out_item_t res_data;

  // divider
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_quo;

  // wrap detect and multi-turn angle
  logic signed [DFW-1:0] d;
  logic [CB-1:0]         ad;
  logic [CB+2:0]         ad5;
  logic                  wrap;
  logic signed [TW-1:0]  t_step;
  logic signed [TW-1:0]  t_new;
  logic signed [PW-1:0]  pa_adj;
  logic signed [AW-1:0]  angle_new;
  logic signed [PW:0]    diff_full;
  logic [31:0]           du;
  logic [DTW-1:0]        dt_new;

  // velocity scaling and electrical angle
  logic [CB-1:0] diff_mag;
  logic [CB-1:0] a_lo;
  logic [CB-1:0] da_lo;
  logic [CB-1:0] elec_prod;
  logic signed [mtenc_pkg::FA_W-1:0] fa_u;

  // saturation
  logic [63:0]                      q64;
  logic [31:0]                      q32;
  logic signed [mtenc_pkg::VEL_W-1:0] vel_sat;

  always_comb begin
    d   = signed'({1'b0, raw_q}) - signed'({1'b0, prev_raw});
    ad  = d[DFW-1] ? CB'(-d) : CB'(d);
    // 5*|d| > 4*CPR, i.e. a jump of more than 0.8 turn
    ad5  = (CB+3)'(ad) + ((CB+3)'(ad) << 2);
    wrap = ad5 > ((CB+3)'(1) << (CB + 2));

    // forward jump across zero means one turn back, and the other way round
    if (wrap) begin
      t_step = d[DFW-1] ? turn_offset + TW'(1) : turn_offset - TW'(1);
    end else begin
      t_step = turn_offset;
    end

    // rebase at the turn limit; previous angle moves with it
    if (!started) begin
      t_new  = '0;
      pa_adj = prev_angle;
    end else if (t_step >= REB_T) begin
      t_new  = '0;
      pa_adj = prev_angle - REB_SPAN;
    end else if (t_step <= -REB_T) begin
      t_new  = '0;
      pa_adj = prev_angle + REB_SPAN;
    end else begin
      t_new  = t_step;
      pa_adj = prev_angle;
    end

    angle_new = {t_new, raw_q};
    diff_full = started ? (PW+1)'(angle_new) - (PW+1)'(pa_adj) : '0;

    // elapsed time: zero, negative or beyond the window falls back to the default
    du = now_q - prev_time;
    if (du == 32'd0 || du > 32'(mtenc_pkg::DT_LIMIT)) begin
      dt_new = DTW'(mtenc_pkg::DT_DEFAULT);
    end else begin
      dt_new = DTW'(du);
    end

    diff_mag  = diff_q[DFW-1] ? CB'(-diff_q) : CB'(diff_q);
    a_lo      = angle_q[CB-1:0];
    da_lo     = reg_dir ? -a_lo : a_lo;
    elec_prod = CB'(da_lo * CB'(reg_pp));
    fa_u      = mtenc_pkg::FA_W'(angle_q);

    q64 = 64'(div_quo);
    q32 = 32'(div_quo);
    if (neg_q) begin
      vel_sat = (q64 > 64'h8000_0000) ? 32'sh8000_0000 : signed'(-q32);
    end else begin
      vel_sat = (q64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q32);
    end
  end

  assign div_start = (state == S_START);

  mtenc_div #(
    .NW(NW),
    .DW(DTW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_q),
    .den  (dt_q),
    .done (div_done),
    .quo  (div_quo)
  );

  // configuration port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_dir  <= 1'b0;
      reg_pp   <= mtenc_pkg::PP_RESET;
      reg_zero <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mtenc_pkg::CFG_DIR:  reg_dir  <= cfg.data[0];
        mtenc_pkg::CFG_PP:   reg_pp   <= cfg.data[mtenc_pkg::PP_W-1:0];
        mtenc_pkg::CFG_ZERO: reg_zero <= cfg.data[mtenc_pkg::ZERO_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: one item in flight
  assign sample.ready = (state == S_IDLE);

  // hand over once the output register is free or being drained
  assign res_load = (state == S_FIN) && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      started     <= 1'b0;
      turn_offset <= '0;
      prev_angle  <= '0;
      prev_raw    <= '0;
      prev_time   <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            raw_q <= CB'(sample.data.raw_count & RAW_MASK);
            now_q <= sample.data.time_us;
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          angle_q     <= angle_new;
          diff_q      <= DFW'(diff_full);
          dt_q        <= dt_new;
          primed_q    <= started;
          prev_raw    <= raw_q;
          turn_offset <= t_new;
          prev_angle  <= PW'(angle_new);
          prev_time   <= now_q;
          started     <= 1'b1;
          state       <= S_MUL;
        end
        S_MUL: begin
          num_q  <= NW'(diff_mag) * NW'(mtenc_pkg::VEL_SCALE);
          neg_q  <= diff_q[DFW-1] ^ reg_dir;
          elec_q <= mtenc_pkg::EA_W'(elec_prod - CB'(reg_zero));
          full_q <= reg_dir ? -fa_u : fa_u;
          state  <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_load) begin
            res_data.full_angle <= full_q;
            res_data.velocity   <= primed_q ? vel_sat : '0;
            res_data.elec_angle <= elec_q;
            res_data.primed     <= primed_q;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

endmodule

/* rtl/mtenc_chk.sv */
`include "multiturn_encoder_angle_velocity_core_defines.svh"

module mtenc_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_valid,
  input logic                                s_ready,
  input logic                                r_valid,
  input logic                                r_ready,
  input logic                                r_primed,
  input logic signed [mtenc_pkg::VEL_W-1:0]  r_velocity
);

  // held result stays offered
  `MTENC_ASSERT_NEXT(a_res_hold, r_valid && !r_ready, r_valid, "result dropped while stalled")

  // a taken sample closes the input
  `MTENC_ASSERT_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready, "input open right after a transfer")

  // a new result comes out of a busy cycle
  `MTENC_ASSERT_NOW(a_res_from_busy, $rose(r_valid), $past(!s_ready), "result appeared while idle")

  // the priming item reports no velocity
  `MTENC_ASSERT_NOW(a_unprimed_zero, r_valid && !r_primed, r_velocity == 0, "velocity on priming item")

endmodule

bind multiturn_encoder_angle_velocity_core mtenc_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (sample.valid),
  .s_ready    (sample.ready),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .r_primed   (result.data.primed),
  .r_velocity (result.data.velocity)
);
